@@ rtl/core/ftdt_pkg.sv @@
// Shared constants and types for the float to decimal text converter.
`timescale 1ns / 1ps

package ftdt_pkg;

    localparam int FRACTION_DIGITS = 6;
    localparam int FDIG_W          = $clog2(FRACTION_DIGITS + 1);
    localparam int FRAC_BITS       = 44;
    localparam int INT_BITS        = 31;
    localparam int INT_DIGITS_MAX  = 10;
    localparam int DIG_IDX_W       = $clog2(INT_DIGITS_MAX);
    localparam int DIG_CNT_W       = $clog2(INT_DIGITS_MAX + 1);
    localparam int RES_W           = FRAC_BITS + 4;

    localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
    localparam int          DIV10_SHIFT = 35;
    localparam logic [7:0]  ERR_EXP     = 8'd158;
    localparam logic [7:0]  CHAR_ZERO   = 8'h30;
    localparam logic [7:0]  CHAR_MINUS  = 8'h2D;
    localparam logic [7:0]  CHAR_DOT    = 8'h2E;

    typedef enum logic [1:0] {
        OP_DIV10,
        OP_REM10,
        OP_MUL10
    } t_op;

    typedef struct packed {
        logic                  en;
        t_op                   op;
        logic [FRAC_BITS-1:0]  a;
        logic [INT_BITS-1:0]   b;
    } t_unit_req;

endpackage

@@ rtl/core/float_to_decimal_text.sv @@
// Float to fixed-notation decimal text converter, top level.
//
// channel  direction  handshake          payload
// input    in         i_valid / o_ready  i_value_bits
// output   out        o_valid / i_ready  o_text_char, o_last_char, o_error_flag
//
// Steps: each integer digit is split off (S_DIV, S_REM, S_STORE), later sent
// (S_INT); S_SIGN runs whether or not a minus prints; then S_DOT; S_FMUL and
// S_FEMIT per fraction digit; then idle. An error item only passes S_ERR. The
// shared step unit sets the pace, one operation per cycle unless stalled.
// Reset is synchronous, active low; no clearing pass is needed after reset.
// A stalled output holds the sequencer in place; input waits until the
// last character of the previous item is in the output register.
`timescale 1ns / 1ps

module float_to_decimal_text (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_value_bits,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_text_char,
    output logic        o_last_char,
    output logic        o_error_flag
);

    localparam int FB = ftdt_pkg::FRAC_BITS;
    localparam int IB = ftdt_pkg::INT_BITS;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ERR,
        S_DIV,
        S_REM,
        S_STORE,
        S_SIGN,
        S_INT,
        S_DOT,
        S_FMUL,
        S_FEMIT
    } t_state;

    t_state                             r_state, n_state;
    logic [IB-1:0]                      r_int, n_int;
    logic [IB-1:0]                      r_quot, n_quot;
    logic [FB-1:0]                      r_frac, n_frac;
    logic                               r_neg, n_neg;
    logic [ftdt_pkg::DIG_CNT_W-1:0]     r_cnt, n_cnt;
    logic [ftdt_pkg::DIG_IDX_W-1:0]     r_idx, n_idx;
    logic [ftdt_pkg::FDIG_W-1:0]        r_fdig, n_fdig;
    logic [3:0]                         r_digits [ftdt_pkg::INT_DIGITS_MAX];
    logic                               wr_en;
    logic                               r_o_valid, n_o_valid;
    logic [7:0]                         r_char, n_char;
    logic                               r_last, n_last;
    logic                               r_err, n_err;

    logic [7:0]                         in_exp;
    logic [23:0]                        in_mant;
    logic signed [9:0]                  in_e;
    logic [IB-1:0]                      in_int;
    logic [FB-1:0]                      in_frac;
    logic                               in_error;
    logic                               accept;
    logic                               slot_free;

    ftdt_pkg::t_unit_req                unit_req;
    logic [ftdt_pkg::RES_W-1:0]         unit_res;

    ftdt_step_unit u_step (
        .i_clk (i_clk),
        .i_req (unit_req),
        .o_res (unit_res)
    );

    assign in_exp   = i_value_bits[30:23];
    assign in_mant  = (in_exp == 8'd0) ? 24'd0 : {1'b1, i_value_bits[22:0]};
    assign in_e     = $signed({2'b00, in_exp}) - 10'sd127;
    assign in_error = (in_exp >= ftdt_pkg::ERR_EXP);

    always_comb begin
        in_int  = '0;
        in_frac = '0;
        if (in_e >= 10'sd0 && in_e <= 10'sd30) begin
            in_int = IB'({in_mant, 7'b0000000} >> 5'(10'sd30 - in_e));
        end
        if (in_e >= -10'sd20 && in_e <= 10'sd22) begin
            in_frac = FB'(68'(in_mant) << 6'(in_e + 10'sd21));
        end
    end

    assign o_ready   = (r_state == S_IDLE);
    assign accept    = i_valid && o_ready;
    assign slot_free = !r_o_valid || i_ready;

    always_comb begin
        unit_req.en = 1'b0;
        unit_req.op = ftdt_pkg::OP_DIV10;
        unit_req.a  = FB'(r_int);
        unit_req.b  = unit_res[IB-1:0];
        unique case (r_state)
            S_DIV: begin
                unit_req.en = 1'b1;
            end
            S_REM: begin
                unit_req.en = 1'b1;
                unit_req.op = ftdt_pkg::OP_REM10;
            end
            S_FMUL: begin
                unit_req.en = 1'b1;
                unit_req.op = ftdt_pkg::OP_MUL10;
                unit_req.a  = r_frac;
            end
            default: begin
                unit_req.en = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_int     = r_int;
        n_quot    = r_quot;
        n_frac    = r_frac;
        n_neg     = r_neg;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        n_fdig    = r_fdig;
        wr_en     = 1'b0;
        n_o_valid = r_o_valid && !i_ready;
        n_char    = r_char;
        n_last    = r_last;
        n_err     = r_err;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_int   = in_int;
                    n_frac  = in_frac;
                    n_neg   = i_value_bits[31] && (i_value_bits[30:0] != 31'd0);
                    n_cnt   = '0;
                    n_fdig  = '0;
                    n_state = in_error ? S_ERR : S_DIV;
                end
            end
            S_ERR: begin
                if (slot_free) begin
                    n_o_valid = 1'b1;
                    n_char    = 8'd0;
                    n_last    = 1'b1;
                    n_err     = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_DIV: begin
                n_state = S_REM;
            end
            S_REM: begin
                n_quot  = unit_res[IB-1:0];
                n_state = S_STORE;
            end
            S_STORE: begin
                wr_en   = (r_cnt < ftdt_pkg::DIG_CNT_W'(ftdt_pkg::INT_DIGITS_MAX));
                n_cnt   = wr_en ? r_cnt + 1'b1 : r_cnt;
                n_int   = r_quot;
                n_state = (r_quot == '0) ? S_SIGN : S_DIV;
            end
            S_SIGN: begin
                n_idx = ftdt_pkg::DIG_IDX_W'(r_cnt - 1'b1);
                if (!r_neg) begin
                    n_state = S_INT;
                end else if (slot_free) begin
                    n_o_valid = 1'b1;
                    n_char    = ftdt_pkg::CHAR_MINUS;
                    n_last    = 1'b0;
                    n_err     = 1'b0;
                    n_state   = S_INT;
                end
            end
            S_INT: begin
                if (slot_free) begin
                    n_o_valid = 1'b1;
                    n_char    = ftdt_pkg::CHAR_ZERO + {4'b0000, r_digits[r_idx]};
                    n_last    = 1'b0;
                    n_err     = 1'b0;
                    n_idx     = r_idx - 1'b1;
                    n_state   = (r_idx == '0) ? S_DOT : S_INT;
                end
            end
            S_DOT: begin
                if (slot_free) begin
                    n_o_valid = 1'b1;
                    n_char    = ftdt_pkg::CHAR_DOT;
                    n_last    = 1'b0;
                    n_err     = 1'b0;
                    n_state   = S_FMUL;
                end
            end
            S_FMUL: begin
                n_state = S_FEMIT;
            end
            S_FEMIT: begin
                if (slot_free) begin
                    n_o_valid = 1'b1;
                    n_char    = ftdt_pkg::CHAR_ZERO + {4'b0000, unit_res[ftdt_pkg::RES_W-1:FB]};
                    n_last    = (r_fdig == ftdt_pkg::FDIG_W'(ftdt_pkg::FRACTION_DIGITS - 1));
                    n_err     = 1'b0;
                    n_frac    = unit_res[FB-1:0];
                    n_fdig    = r_fdig + 1'b1;
                    n_state   = n_last ? S_IDLE : S_FMUL;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            r_cnt     <= '0;
            r_fdig    <= '0;
            r_int     <= '0;
            r_frac    <= '0;
            r_neg     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
            r_cnt     <= n_cnt;
            r_fdig    <= n_fdig;
            r_int     <= n_int;
            r_frac    <= n_frac;
            r_neg     <= n_neg;
        end
        r_quot <= n_quot;
        r_idx  <= n_idx;
        r_char <= n_char;
        r_last <= n_last;
        r_err  <= n_err;
        if (wr_en) begin
            r_digits[r_cnt[ftdt_pkg::DIG_IDX_W-1:0]] <= unit_res[3:0];
        end
    end

    assign o_valid      = r_o_valid;
    assign o_text_char  = r_char;
    assign o_last_char  = r_last;
    assign o_error_flag = r_err;

`ifndef ASSERT_OFF
    a_err_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error_flag |-> o_last_char && (o_text_char == 8'd0))
        else $error("error item must be a single zero character");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= ftdt_pkg::DIG_CNT_W'(ftdt_pkg::INT_DIGITS_MAX))
        else $error("integer digit count out of range");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("block ready right after taking an item");
`endif

endmodule

@@ rtl/core/ftdt_step_unit.sv @@
// Shared decimal step unit: divide by ten, remainder by ten, fraction times ten.
`timescale 1ns / 1ps

module ftdt_step_unit (
    input  logic                          i_clk,
    input  ftdt_pkg::t_unit_req           i_req,
    output logic [ftdt_pkg::RES_W-1:0]    o_res
);

    logic [62:0]                  prod;
    logic [33:0]                  times_ten;
    logic [33:0]                  rem_full;
    logic [ftdt_pkg::RES_W-1:0]   n_res;
    logic [ftdt_pkg::RES_W-1:0]   r_res;

    assign prod      = 63'(i_req.a[ftdt_pkg::INT_BITS-1:0]) * 63'(ftdt_pkg::DIV10_RECIP);
    assign times_ten = {i_req.b, 3'b000} + {2'b00, i_req.b, 1'b0};
    assign rem_full  = 34'(i_req.a[ftdt_pkg::INT_BITS-1:0]) - times_ten;

    always_comb begin
        case (i_req.op)
            ftdt_pkg::OP_DIV10: n_res = ftdt_pkg::RES_W'(prod[62:ftdt_pkg::DIV10_SHIFT]);
            ftdt_pkg::OP_REM10: n_res = ftdt_pkg::RES_W'(rem_full[3:0]);
            ftdt_pkg::OP_MUL10: n_res = {1'b0, i_req.a, 3'b000} + {3'b000, i_req.a, 1'b0};
            default:            n_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule
